// ===== design/assert_macros.svh =====
// Assertion macros shared by the output fault monitor RTL.
// Clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define OFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset
`define OFM_ASSERT_NEVER(label, cond, msg) \
    `OFM_ASSERT(label, !(cond), msg)

`endif

// ===== design/ofm_pkg.sv =====
// Types and constants for the output fault monitor.
// No dependencies; used by ofm_eval and output_fault_monitor.
`timescale 1ns / 1ps

package ofm_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CHECK_INTERVAL = 3'd0,
        REG_FAN_STALL      = 3'd1,
        REG_PUMP_DRY       = 3'd2,
        REG_FAN_RPM_MIN    = 3'd3,
        REG_LEAK_FLOW      = 3'd4
    } reg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 88;
    localparam int unsigned OUT_DATA_W  = 16;

    // Register reset values
    localparam logic [15:0] RST_CHECK_INTERVAL = 16'd100;
    localparam logic [15:0] RST_FAN_STALL      = 16'd3000;
    localparam logic [15:0] RST_PUMP_DRY       = 16'd5000;
    localparam logic [15:0] RST_FAN_RPM_MIN    = 16'd50;
    localparam logic [15:0] RST_LEAK_FLOW      = 16'd100;

    // Fault flag bit positions
    localparam int unsigned FLAG_FAN        = 0;
    localparam int unsigned FLAG_PUMP       = 1;
    localparam int unsigned FLAG_IRRIGATION = 2;
    localparam int unsigned FLAG_CURTAIN    = 3;
    localparam int unsigned FLAG_BUZZER     = 4;
    localparam int unsigned FLAG_ALARM_LED  = 5;
    localparam int unsigned FLAG_LIGHT      = 6;
    localparam int unsigned FLAG_FLOW_LEAK  = 7;

    // Drive bit positions
    localparam int unsigned DRV_FAN        = 0;
    localparam int unsigned DRV_PUMP       = 1;
    localparam int unsigned DRV_IRRIGATION = 2;
    localparam int unsigned DRV_CURTAIN    = 3;
    localparam int unsigned DRV_BUZZER     = 4;
    localparam int unsigned DRV_ALARM_LED  = 5;
    localparam int unsigned DRV_LIGHT      = 6;

    // Feedback pin positions
    localparam int unsigned FB_IRRIGATION = 0;
    localparam int unsigned FB_CURT_FWD   = 1;
    localparam int unsigned FB_CURT_REV   = 2;
    localparam int unsigned FB_BUZZER     = 3;
    localparam int unsigned FB_ALARM_LED  = 4;

    typedef struct packed {
        logic [15:0] check_interval_ms;
        logic [15:0] fan_stall_ms;
        logic [15:0] pump_dry_ms;
        logic [15:0] fan_rpm_min;
        logic [15:0] leak_flow_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] fan_speed;
        logic [15:0] flow_rate;
        logic [6:0]  drive_on;
        logic [4:0]  feedback_pins;
        logic [7:0]  led_pins;
    } item_t;

    typedef struct packed {
        logic [31:0] last_check_time;
        logic [7:0]  flag_store;
        logic [31:0] fan_low_time;
        logic [31:0] pump_dry_time;
    } state_t;

endpackage

// ===== design/ofm_eval.sv =====
// Evaluation logic of the output fault monitor: next state and flags for one snapshot.
// Depends on ofm_pkg.
`timescale 1ns / 1ps

module ofm_eval
(
    input  ofm_pkg::cfg_t   cfg,
    input  ofm_pkg::item_t  item,
    input  ofm_pkg::state_t st,
    output ofm_pkg::state_t st_next,
    output logic            eval
);

    logic [31:0] elapsed;
    logic        fan_low;
    logic        pump_dry;
    logic [32:0] fan_sum;
    logic [32:0] pump_sum;
    logic [31:0] fan_acc;
    logic [31:0] pump_acc;
    logic [7:0]  flags;

    // Wrapping tick difference against the last evaluation
    assign elapsed = item.time_ms - st.last_check_time;
    assign eval    = (elapsed >= {16'd0, cfg.check_interval_ms});

    // Low conditions for the timed faults
    assign fan_low  = item.drive_on[ofm_pkg::DRV_FAN] && (item.fan_speed < cfg.fan_rpm_min);
    assign pump_dry = item.drive_on[ofm_pkg::DRV_PUMP] && (item.flow_rate == 16'd0);

    // Saturating duration accumulators
    assign fan_sum  = {1'b0, st.fan_low_time} + {1'b0, elapsed};
    assign pump_sum = {1'b0, st.pump_dry_time} + {1'b0, elapsed};
    assign fan_acc  = fan_sum[32] ? 32'hFFFF_FFFF : fan_sum[31:0];
    assign pump_acc = pump_sum[32] ? 32'hFFFF_FFFF : pump_sum[31:0];

    // Flag update; timed flags stay set while the condition lasts
    always_comb
    begin
        flags = st.flag_store;

        if (!fan_low)
        begin
            flags[ofm_pkg::FLAG_FAN] = 1'b0;
        end
        else if (fan_acc >= {16'd0, cfg.fan_stall_ms})
        begin
            flags[ofm_pkg::FLAG_FAN] = 1'b1;
        end

        if (!pump_dry)
        begin
            flags[ofm_pkg::FLAG_PUMP] = 1'b0;
        end
        else if (pump_acc >= {16'd0, cfg.pump_dry_ms})
        begin
            flags[ofm_pkg::FLAG_PUMP] = 1'b1;
        end

        flags[ofm_pkg::FLAG_IRRIGATION] = item.drive_on[ofm_pkg::DRV_IRRIGATION]
                                          && !item.feedback_pins[ofm_pkg::FB_IRRIGATION];
        flags[ofm_pkg::FLAG_CURTAIN]    = item.drive_on[ofm_pkg::DRV_CURTAIN]
                                          && item.feedback_pins[ofm_pkg::FB_CURT_FWD]
                                          && item.feedback_pins[ofm_pkg::FB_CURT_REV];
        flags[ofm_pkg::FLAG_BUZZER]     = item.drive_on[ofm_pkg::DRV_BUZZER]
                                          && !item.feedback_pins[ofm_pkg::FB_BUZZER];
        flags[ofm_pkg::FLAG_ALARM_LED]  = item.drive_on[ofm_pkg::DRV_ALARM_LED]
                                          && !item.feedback_pins[ofm_pkg::FB_ALARM_LED];
        flags[ofm_pkg::FLAG_LIGHT]      = item.drive_on[ofm_pkg::DRV_LIGHT]
                                          && (item.led_pins == 8'd0);
        flags[ofm_pkg::FLAG_FLOW_LEAK]  = !item.drive_on[ofm_pkg::DRV_PUMP]
                                          && (item.flow_rate > cfg.leak_flow_limit);
    end

    // State moves only on an evaluation
    always_comb
    begin
        st_next = st;
        if (eval)
        begin
            st_next.last_check_time = item.time_ms;
            st_next.flag_store      = flags;
            st_next.fan_low_time    = fan_low ? fan_acc : 32'd0;
            st_next.pump_dry_time   = pump_dry ? pump_acc : 32'd0;
        end
    end

endmodule

// ===== design/output_fault_monitor.sv =====
// Output fault monitor top level; depends on ofm_pkg, ofm_eval and assert_macros.svh.
// Usage:
//   s_axis_* carries one snapshot per transfer (time, speeds, drive and feedback levels).
//   m_axis_* returns exactly one result per snapshot, in order: the stored fault flags,
//   an any-fault bit and a bit saying whether this snapshot ran an evaluation.
//   cfg_* writes one 16-bit register per transfer (0 check interval, 1 fan stall time,
//   2 pump dry time, 3 fan rpm minimum, 4 leak flow limit); other indexes are ignored.
//   cfg_ready is always high; write only while no snapshot is in flight.
// Timing:
//   A snapshot is captured in the input register at its transfer and evaluated from that
//   register; the result register loads when the result slot is free or being drained,
//   and m_axis_tvalid is driven from the result register. One snapshot per cycle is
//   sustained while m_axis_tready stays high; the limit is the single state update of the
//   interval/duration logic, performed once per cycle.
// Reset:
//   rst_n clears the pipeline, all timing state and flags, and loads the register
//   defaults (100, 3000, 5000, 50, 100).
// Back-pressure:
//   While m_axis_tready is low the result holds; the input register still takes one
//   more snapshot, after which s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module output_fault_monitor
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Snapshot input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] time_ms, [47:32] fan_speed, [63:48] flow_rate, [70:64] drive_on,
    // [75:71] feedback_pins, [83:76] led_pins, [87:84] zero
    input  logic [ofm_pkg::IN_DATA_W-1:0]       s_axis_tdata,

    // Result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] fault_flags, [8] any_fault, [9] evaluated, [15:10] zero
    output logic [ofm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,

    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ofm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ofm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ofm_pkg::cfg_t   cfg_reg;
    ofm_pkg::state_t state_reg;
    ofm_pkg::state_t state_next;
    ofm_pkg::item_t  in_item_reg;
    ofm_pkg::item_t  in_item;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic [9:0]      out_data_reg;
    logic            advance;
    logic            eval;

    // Unpack the snapshot
    assign in_item.time_ms       = s_axis_tdata[31:0];
    assign in_item.fan_speed     = s_axis_tdata[47:32];
    assign in_item.flow_rate     = s_axis_tdata[63:48];
    assign in_item.drive_on      = s_axis_tdata[70:64];
    assign in_item.feedback_pins = s_axis_tdata[75:71];
    assign in_item.led_pins      = s_axis_tdata[83:76];

    // Handshakes: evaluation moves when the result slot is free or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_interval_ms <= ofm_pkg::RST_CHECK_INTERVAL;
            cfg_reg.fan_stall_ms      <= ofm_pkg::RST_FAN_STALL;
            cfg_reg.pump_dry_ms       <= ofm_pkg::RST_PUMP_DRY;
            cfg_reg.fan_rpm_min       <= ofm_pkg::RST_FAN_RPM_MIN;
            cfg_reg.leak_flow_limit   <= ofm_pkg::RST_LEAK_FLOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ofm_pkg::REG_CHECK_INTERVAL: cfg_reg.check_interval_ms <= cfg_data;
                ofm_pkg::REG_FAN_STALL:      cfg_reg.fan_stall_ms      <= cfg_data;
                ofm_pkg::REG_PUMP_DRY:       cfg_reg.pump_dry_ms       <= cfg_data;
                ofm_pkg::REG_FAN_RPM_MIN:    cfg_reg.fan_rpm_min       <= cfg_data;
                ofm_pkg::REG_LEAK_FLOW:      cfg_reg.leak_flow_limit   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= in_item;
        end
    end

    // Evaluation
    ofm_eval u_eval
    (
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .eval    (eval)
    );

    // Pipeline control and monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= {eval, |state_next.flag_store, state_next.flag_store};
        end
    end

    // Checks
    `OFM_ASSERT(a_any_fault, out_valid_reg |-> (out_data_reg[8] == |out_data_reg[7:0]), "any_fault does not match the fault flags")
    `OFM_ASSERT(a_no_eval_flags, (out_valid_reg && !out_data_reg[9]) |-> (out_data_reg[7:0] == state_reg.flag_store), "non-evaluated result differs from stored flags")
    `OFM_ASSERT(a_in_held, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)), "stalled snapshot lost from the input register")
    `OFM_ASSERT_NEVER(a_state_moves_stalled, !$past(advance) && !$stable(state_reg), "state changed while stalled")

endmodule
